// ===== hdl/nf4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nf4_pkg
// shared constants, code tables and the per-lane status struct
// ----------------------------------------------------------------------------
package nf4_pkg;

    localparam int LANES = 2;

    localparam logic CODE_FMT_NF4 = 1'b0;
    localparam logic CODE_FMT_FP4 = 1'b1;

    localparam logic [15:0] BF16_QNAN     = 16'hFFC0;
    localparam logic [15:0] BF16_QUIET    = 16'h0040;
    localparam logic [14:0] BF16_INF_MAG  = 15'h7F80;
    localparam logic [7:0]  EXP_ALL_ONES  = 8'hFF;
    localparam logic [9:0]  EXP_BIAS      = 10'd127;

    // stage-one result of a lane: special case resolved or product pending
    typedef struct packed {
        logic        special;
        logic [15:0] special_val;
        logic        sign;
        logic [9:0]  exp;
        logic [15:0] prod;
    } t_lane_mid;

    function automatic logic [15:0] code_value(input logic fmt, input logic [3:0] code);
        logic [15:0] v;
        v = 16'h0000;
        if (fmt == CODE_FMT_NF4) begin
            case (code)
                4'd0:  v = 16'hBF80;
                4'd1:  v = 16'hBF32;
                4'd2:  v = 16'hBF06;
                4'd3:  v = 16'hBECA;
                4'd4:  v = 16'hBE92;
                4'd5:  v = 16'hBE3D;
                4'd6:  v = 16'hBDBA;
                4'd7:  v = 16'h0000;
                4'd8:  v = 16'h3DA3;
                4'd9:  v = 16'h3E25;
                4'd10: v = 16'h3E7C;
                4'd11: v = 16'h3EAD;
                4'd12: v = 16'h3EE2;
                4'd13: v = 16'h3F10;
                4'd14: v = 16'h3F39;
                4'd15: v = 16'h3F80;
                default: v = 16'h0000;
            endcase
        end else begin
            case (code)
                4'd0:  v = 16'h0000;
                4'd1:  v = 16'h3BAB;
                4'd2:  v = 16'h3F2B;
                4'd3:  v = 16'h3F80;
                4'd4:  v = 16'h3EAB;
                4'd5:  v = 16'h3F00;
                4'd6:  v = 16'h3E2B;
                4'd7:  v = 16'h3E80;
                4'd8:  v = 16'h0000;
                4'd9:  v = 16'hBBAB;
                4'd10: v = 16'hBF2B;
                4'd11: v = 16'hBF80;
                4'd12: v = 16'hBEAB;
                4'd13: v = 16'hBF00;
                4'd14: v = 16'hBE2B;
                4'd15: v = 16'hBE80;
                default: v = 16'h0000;
            endcase
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/nf4_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nf4_lane
// one lane: table lookup and 8x8 mantissa multiply, then round to bfloat16
// ----------------------------------------------------------------------------
module nf4_lane (
    input  wire logic        i_clk,
    input  wire logic        i_en1,
    input  wire logic        i_en2,
    input  wire logic        i_fmt,
    input  wire logic [3:0]  i_code,
    input  wire logic [15:0] i_scale,
    output logic      [15:0] o_weight
);
    import nf4_pkg::*;

    t_lane_mid   r_mid, n_mid;
    logic [15:0] r_weight, n_weight;

    always_comb begin
        logic [15:0] a;
        logic [7:0]  ea, eb;
        logic [6:0]  mb;
        logic        s;
        a  = code_value(i_fmt, i_code);
        ea = a[14:7];
        eb = i_scale[14:7];
        mb = i_scale[6:0];
        s  = a[15] ^ i_scale[15];
        n_mid.sign        = s;
        n_mid.exp         = {2'b00, ea} + {2'b00, eb} - EXP_BIAS;
        n_mid.prod        = {8'h00, 1'b1, a[6:0]} * {8'h00, 1'b1, mb};
        n_mid.special     = 1'b1;
        n_mid.special_val = {s, 15'h0000};
        if (eb == EXP_ALL_ONES && mb != 7'd0) begin
            n_mid.special_val = i_scale | BF16_QUIET;
        end else if (eb == EXP_ALL_ONES) begin
            n_mid.special_val = (ea == 8'd0) ? BF16_QNAN : {s, BF16_INF_MAG};
        end else if (ea == 8'd0 || eb == 8'd0) begin
            n_mid.special_val = {s, 15'h0000};
        end else begin
            n_mid.special = 1'b0;
        end
    end

    always_comb begin
        logic [9:0]  e;
        logic [9:0]  e_pre;
        logic [15:0] p;
        logic [8:0]  q;
        logic [7:0]  r;
        e = r_mid.exp;
        p = r_mid.prod;
        if (p[15]) begin
            e = e + 10'd1;
        end else begin
            p = {p[14:0], 1'b0};
        end
        // flush decision is taken on the exponent before rounding
        e_pre = e;
        q = {1'b0, p[15:8]};
        r = p[7:0];
        if (r > 8'h80 || (r == 8'h80 && q[0])) begin
            q = q + 9'd1;
        end
        if (q[8]) begin
            e = e + 10'd1;
        end
        // e is signed 10-bit: negative or zero flushes, 255 and up overflows
        if (r_mid.special) begin
            n_weight = r_mid.special_val;
        end else if (e_pre[9] || e_pre == 10'd0) begin
            n_weight = {r_mid.sign, 15'h0000};
        end else if (e >= 10'd255) begin
            n_weight = {r_mid.sign, BF16_INF_MAG};
        end else begin
            n_weight = {r_mid.sign, e[7:0], q[8] ? 7'd0 : q[6:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) r_mid <= n_mid;
        if (i_en2) r_weight <= n_weight;
    end

    assign o_weight = r_weight;

endmodule
`default_nettype wire

// ===== hdl/nf4_fp4_dequantizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nf4_fp4_dequantizer
// two bfloat16 weights per packed byte from an NF4 or FP4 code table
// ----------------------------------------------------------------------------
// path: an accepted transaction goes through lookup/multiply, then round, to o_valid
// throughput: one transaction per cycle while i_stall does not hold the two-stage lane pipeline
// reset: synchronous active-low i_rst_n clears valids and selects the NF4 table
module nf4_fp4_dequantizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_packed_byte,
    input  wire logic [15:0] i_scale_low,
    input  wire logic [15:0] i_scale_high,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [15:0] o_weight_low,
    output logic      [15:0] o_weight_high
);
    import nf4_pkg::*;

    logic r_fmt;
    logic r_v1, r_v2;
    logic adv2, adv1;
    logic [15:0] w_lane [2];

    // stage two holds when its result is stalled; stage one moves if empty or two moves
    assign adv2    = !r_v2 || !i_stall;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= CODE_FMT_NF4;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (i_cfg_we) r_fmt <= i_cfg_data;
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    // low nibble lane and high nibble lane
    nf4_lane u_lane0 (
        .i_clk(i_clk), .i_en1(adv1), .i_en2(adv2), .i_fmt(r_fmt),
        .i_code(i_packed_byte[3:0]), .i_scale(i_scale_low), .o_weight(w_lane[0])
    );
    nf4_lane u_lane1 (
        .i_clk(i_clk), .i_en1(adv1), .i_en2(adv2), .i_fmt(r_fmt),
        .i_code(i_packed_byte[7:4]), .i_scale(i_scale_high), .o_weight(w_lane[1])
    );

    // merge: lanes at or past LANES read as zero
    assign o_valid       = r_v2;
    assign o_weight_low  = (LANES > 0) ? w_lane[0] : 16'h0000;
    assign o_weight_high = (LANES > 1) ? w_lane[1] : 16'h0000;

endmodule
`default_nettype wire

// ===== bench/tb_nf4_fp4_dequantizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nf4_fp4_dequantizer
// self-checking bench: directed table then random transactions, scoreboarded
// against a behavioral bfloat16 scaling model, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_nf4_fp4_dequantizer;
    import nf4_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM    = 600;
    localparam int DRAIN_WAIT  = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_packed_byte = '0;
    logic [15:0] i_scale_low = '0;
    logic [15:0] i_scale_high = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_weight_low;
    logic [15:0] o_weight_high;

    nf4_fp4_dequantizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_packed_byte(i_packed_byte), .i_scale_low(i_scale_low),
        .i_scale_high(i_scale_high),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_weight_low(o_weight_low), .o_weight_high(o_weight_high)
    );

    always #2 i_clk = ~i_clk;

    // expected weight pairs, oldest first
    typedef struct packed {
        logic [15:0] w_lo;
        logic [15:0] w_hi;
    } t_weight_pair;

    t_weight_pair pending_weights[$];
    logic         table_sel = CODE_FMT_NF4;
    int           n_errors = 0;
    int           n_checked = 0;
    int           n_special = 0;
    int           cycle_cnt = 0;
    bit           idle_enable = 1'b1;
    bit           long_holdoff = 1'b0;

    // own copy of the code tables
    logic [15:0] nf4_codes [16] = '{
        16'hBF80, 16'hBF32, 16'hBF06, 16'hBECA, 16'hBE92, 16'hBE3D, 16'hBDBA, 16'h0000,
        16'h3DA3, 16'h3E25, 16'h3E7C, 16'h3EAD, 16'h3EE2, 16'h3F10, 16'h3F39, 16'h3F80};
    logic [15:0] fp4_codes [16] = '{
        16'h0000, 16'h3BAB, 16'h3F2B, 16'h3F80, 16'h3EAB, 16'h3F00, 16'h3E2B, 16'h3E80,
        16'h0000, 16'hBBAB, 16'hBF2B, 16'hBF80, 16'hBEAB, 16'hBF00, 16'hBE2B, 16'hBE80};

    // bfloat16 product of a table entry and a scale, round to nearest even
    function automatic logic [15:0] scaled_weight(input logic [15:0] w, input logic [15:0] s);
        logic        sgn;
        logic [7:0]  ew, es;
        logic [15:0] mant;
        logic [8:0]  q;
        logic [7:0]  r;
        int          e;
        sgn  = w[15] ^ s[15];
        ew   = w[14:7];
        es   = s[14:7];
        if (es == 8'hFF && s[6:0] != 0) return s | 16'h0040;
        if (es == 8'hFF) return (ew == 0) ? 16'hFFC0 : {sgn, 15'h7F80};
        if (ew == 0 || es == 0) return {sgn, 15'h0};
        mant = {8'h0, 1'b1, w[6:0]} * {8'h0, 1'b1, s[6:0]};
        e = int'(ew) + int'(es) - 127;
        if (mant[15]) e = e + 1;
        else mant = mant << 1;
        if (e <= 0) return {sgn, 15'h0};
        if (e >= 255) return {sgn, 15'h7F80};
        q = {1'b0, mant[15:8]};
        r = mant[7:0];
        if (r > 8'h80 || (r == 8'h80 && q[0])) q = q + 1;
        if (q == 9'h100) begin
            q = 9'h080;
            e = e + 1;
            if (e >= 255) return {sgn, 15'h7F80};
        end
        return {sgn, e[7:0], q[6:0]};
    endfunction

    function automatic t_weight_pair dequant_pair(input logic sel, input logic [7:0] b,
                                                  input logic [15:0] sl, input logic [15:0] sh);
        t_weight_pair p;
        p.w_lo = scaled_weight(sel ? fp4_codes[b[3:0]] : nf4_codes[b[3:0]], sl);
        p.w_hi = scaled_weight(sel ? fp4_codes[b[7:4]] : nf4_codes[b[7:4]], sh);
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("mismatch %s (result %0d)", msg, n_checked);
    endtask

    // random input stall; long hold-off stretch when requested
    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (long_holdoff) begin
                i_stall <= 1'b1;
                for (hold = 0; hold < 60; hold++) @(posedge i_clk);
                long_holdoff = 1'b0;
                i_stall <= 1'b0;
            end else begin
                i_stall <= idle_enable && ($urandom_range(99) < 21);
            end
        end
    end

    // result checker against oldest expectation
    always @(posedge i_clk) begin
        t_weight_pair exp_p;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_weights.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h %h",
                                          o_weight_low, o_weight_high));
            end else begin
                exp_p = pending_weights.pop_front();
                if (o_weight_low !== exp_p.w_lo)
                    report_mismatch($sformatf("weight_low: got %h expected %h",
                                              o_weight_low, exp_p.w_lo));
                if (o_weight_high !== exp_p.w_hi)
                    report_mismatch($sformatf("weight_high: got %h expected %h",
                                              o_weight_high, exp_p.w_hi));
            end
            n_checked++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    // offer one transaction and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic [15:0] sl, input logic [15:0] sh);
        while (idle_enable && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_packed_byte <= b;
        i_scale_low   <= sl;
        i_scale_high  <= sh;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_weights.push_back(dequant_pair(table_sel, b, sl, sh));
    endtask

    // drain, then write the format register while idle
    task automatic set_format(input logic sel);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_weights.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= sel;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        table_sel = sel;
    endtask

    function automatic logic [15:0] random_scale();
        int k;
        k = $urandom_range(99);
        if (k < 70) return {1'($urandom), 8'($urandom_range(100, 150)), 7'($urandom)};
        if (k < 78) return {1'($urandom), 8'hFF, 7'($urandom)};
        if (k < 84) return {1'($urandom), 8'h00, 7'($urandom)};
        if (k < 92) return {1'($urandom), 8'($urandom_range(250, 254)), 7'($urandom)};
        return 16'($urandom);
    endfunction

    // directed rows: byte, scales, checked value where obvious
    typedef struct {
        logic [7:0]  byte_in;
        logic [15:0] s_lo;
        logic [15:0] s_hi;
        bit          typed;
        logic [15:0] w_lo;
        logic [15:0] w_hi;
    } t_stim_row;

    t_stim_row nf4_rows[] = '{
        '{8'hF0, 16'h3F80, 16'h3F80, 1, 16'hBF80, 16'h3F80},  // unit scale extremes
        '{8'h77, 16'h3F80, 16'h4000, 1, 16'h0000, 16'h0000},  // zero entry
        '{8'h0F, 16'h7FC1, 16'hFF81, 1, 16'h7FC1, 16'hFFC1},  // nan scale quieted
        '{8'h70, 16'h7F80, 16'hFF80, 1, 16'hFF80, 16'hFFC0},  // inf times zero
        '{8'hF0, 16'h0001, 16'h8000, 1, 16'h8000, 16'h8000},  // subnormal and zero
        '{8'h00, 16'h7F7F, 16'h0080, 0, 0, 0},                // largest and smallest normal scales
        '{8'hE8, 16'h7F7F, 16'h00FF, 0, 0, 0},
        '{8'hFF, 16'hFFFF, 16'h7F7F, 0, 0, 0},
        '{8'h9A, 16'h3FC1, 16'hC0A5, 0, 0, 0}
    };
    t_stim_row fp4_rows[] = '{
        '{8'h80, 16'h3F80, 16'h3F80, 1, 16'h0000, 16'h0000},  // both zero codes
        '{8'hB3, 16'h3F80, 16'h3F80, 1, 16'h3F80, 16'hBF80},
        '{8'h08, 16'h7F80, 16'h7F80, 1, 16'hFFC0, 16'hFFC0},
        '{8'h91, 16'h00A5, 16'h7F7F, 0, 0, 0},
        '{8'h3B, 16'h7F7F, 16'hFF7F, 0, 0, 0},
        '{8'h5D, 16'h0081, 16'h4321, 0, 0, 0},
        '{8'hFF, 16'hFFFF, 16'h0000, 0, 0, 0}
    };

    task automatic run_rows(input t_stim_row rows[]);
        t_weight_pair p;
        foreach (rows[i]) begin
            if (rows[i].typed) begin
                p = dequant_pair(table_sel, rows[i].byte_in, rows[i].s_lo, rows[i].s_hi);
                if (p.w_lo !== rows[i].w_lo || p.w_hi !== rows[i].w_hi)
                    report_mismatch($sformatf("table row %0d disagrees with model", i));
                n_special++;
            end
            send_item(rows[i].byte_in, rows[i].s_lo, rows[i].s_hi);
        end
    endtask

    initial begin
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, nf4 from reset then fp4
        run_rows(nf4_rows);
        set_format(CODE_FMT_FP4);
        run_rows(fp4_rows);
        set_format(CODE_FMT_NF4);

        // random part in phases, format flips between phases
        for (n = 0; n < N_RANDOM; n++) begin
            if (n == 150) long_holdoff = 1'b1;       // block fills and stalls input
            if (n == 200) idle_enable = 1'b0;        // stretch with no idling
            if (n == 320) idle_enable = 1'b1;
            if (n == 250) begin                      // sender pause until drained
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_weights.size() != 0) @(posedge i_clk);
            end
            if (n % 150 == 75) set_format(~table_sel);
            send_item(8'($urandom), random_scale(), random_scale());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_weights.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("checked %0d weight pairs over both code tables, %0d typed rows",
                 n_checked, n_special);
        $display("special scales covered: nan, inf, zero, subnormal, overflow");
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== nf4_fp4_dequantizer.f =====
hdl/nf4_pkg.sv
hdl/nf4_lane.sv
hdl/nf4_fp4_dequantizer.sv
bench/tb_nf4_fp4_dequantizer.sv
